// ===== hw/rtl/satl_pkg.sv =====
// ----------------------------------------------------------------------------
// satl_pkg
// Shared constants, register indexes, result type and LFSR step for the
// set-associative cache tag lookup.
// ----------------------------------------------------------------------------
package satl_pkg;

	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 3;
	localparam int SETS_LOG2_W = 3;
	localparam int WAYS_LOG2_W = 2;
	localparam int WAY_OUT_W   = 3;
	localparam int SET_OUT_W   = 6;
	localparam int WAY_IDX_W   = 4;
	localparam int LFSR_W      = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_SETS_LOG2 = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WAYS_LOG2 = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_POLICY    = 2'd2;

	localparam logic POLICY_LRU    = 1'b0;
	localparam logic POLICY_RANDOM = 1'b1;

	localparam logic [SETS_LOG2_W-1:0] SETS_LOG2_RST = 3'd3;
	localparam logic [WAYS_LOG2_W-1:0] WAYS_LOG2_RST = 2'd0;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

	typedef struct packed {
		logic                 hit;
		logic [WAY_IDX_W-1:0] way;
		logic                 victim_was_valid;
	} satl_result_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
		logic [LFSR_W-1:0] nxt;
		nxt = cur >> 1;
		if (cur[0]) begin
			nxt = nxt ^ LFSR_TAPS;
		end
		return nxt;
	endfunction

endpackage

// ===== hw/rtl/satl_tag_store.sv =====
// ----------------------------------------------------------------------------
// satl_tag_store
// One row per set holding valid, tag and age of every way. Synchronous read
// with a registered output; rows never written since reset read with valid and age cleared.
// ----------------------------------------------------------------------------
module satl_tag_store #(
	parameter int NROWS     = 64,
	parameter int SET_W     = 6,
	parameter int NWAYS     = 8,
	parameter int TAG_W     = 30,
	parameter int AGE_WIDTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [SET_W-1:0]                    rd_addr,
	output logic [NWAYS-1:0]                    rd_valid,
	output logic [NWAYS-1:0][TAG_W-1:0]         rd_tag,
	output logic [NWAYS-1:0][AGE_WIDTH-1:0]     rd_age,
	input  logic                                wr_en,
	input  logic [SET_W-1:0]                    wr_addr,
	input  logic [NWAYS-1:0]                    wr_valid,
	input  logic [NWAYS-1:0][TAG_W-1:0]         wr_tag,
	input  logic [NWAYS-1:0][AGE_WIDTH-1:0]     wr_age
);

	localparam int ROW_W = NWAYS * (1 + TAG_W + AGE_WIDTH);

	logic [ROW_W-1:0] mem [NROWS];
	logic [ROW_W-1:0] rd_q;
	logic [NROWS-1:0] row_init_q;
	logic             rd_init_q;

	logic [NWAYS-1:0]                raw_valid;
	logic [NWAYS-1:0][AGE_WIDTH-1:0] raw_age;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_valid, wr_tag, wr_age};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			rd_init_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_init_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= row_init_q[rd_addr];
			end
		end
	end

	assign {raw_valid, rd_tag, raw_age} = rd_q;
	assign rd_valid = rd_init_q ? raw_valid : '0;
	assign rd_age   = rd_init_q ? raw_age : '0;

endmodule

// ===== hw/rtl/satl_update.sv =====
// ----------------------------------------------------------------------------
// satl_update
// Tag compare, age update and victim choice for one set row; builds the row
// to write back and the lookup result.
// ----------------------------------------------------------------------------
module satl_update
	import satl_pkg::*;
#(
	parameter int NWAYS     = 8,
	parameter int WAY_W     = 3,
	parameter int TAG_W     = 30,
	parameter int AGE_WIDTH = 8
) (
	input  logic [NWAYS-1:0]                old_valid,
	input  logic [NWAYS-1:0][TAG_W-1:0]     old_tag,
	input  logic [NWAYS-1:0][AGE_WIDTH-1:0] old_age,
	input  logic [TAG_W-1:0]                tag,
	input  logic [WAYS_LOG2_W-1:0]          ways_log2,
	input  logic                            policy,
	input  logic [LFSR_W-1:0]               lfsr,
	output logic [NWAYS-1:0]                new_valid,
	output logic [NWAYS-1:0][TAG_W-1:0]     new_tag,
	output logic [NWAYS-1:0][AGE_WIDTH-1:0] new_age,
	output satl_result_t                    result
);

	localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

	logic [WAY_W-1:0]                way_mask;
	logic [NWAYS-1:0]                in_use;
	logic [NWAYS-1:0]                match;
	logic [NWAYS-1:0][AGE_WIDTH-1:0] aged;
	logic                            any_hit;
	logic [WAY_W-1:0]                hit_way;
	logic [WAY_W-1:0]                lru_way;
	logic [WAY_W-1:0]                victim;
	logic [AGE_WIDTH-1:0]            best;

	assign way_mask = WAY_W'((1 << ways_log2) - 1);

	always_comb begin
		for (int w = 0; w < NWAYS; w++) begin
			in_use[w] = (WAY_W'(w) & ~way_mask) == '0;
			match[w]  = in_use[w] && old_valid[w] && (old_tag[w] == tag);
			if (match[w]) begin
				aged[w] = '0;
			end else if (old_age[w] == AGE_MAX) begin
				aged[w] = AGE_MAX;
			end else begin
				aged[w] = old_age[w] + AGE_WIDTH'(1);
			end
		end
	end

	assign any_hit = |match;

	always_comb begin
		hit_way = '0;
		for (int w = NWAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		best    = aged[0];
		lru_way = '0;
		for (int w = 1; w < NWAYS; w++) begin
			if (in_use[w] && (aged[w] > best)) begin
				best    = aged[w];
				lru_way = WAY_W'(w);
			end
		end
	end

	assign victim = (policy == POLICY_RANDOM) ? (WAY_W'(lfsr) & way_mask) : lru_way;

	always_comb begin
		for (int w = 0; w < NWAYS; w++) begin
			new_valid[w] = old_valid[w];
			new_tag[w]   = old_tag[w];
			new_age[w]   = in_use[w] ? aged[w] : old_age[w];
			if (!any_hit && (WAY_W'(w) == victim)) begin
				new_valid[w] = 1'b1;
				new_tag[w]   = tag;
				new_age[w]   = '0;
			end
		end
	end

	always_comb begin
		result.hit              = any_hit;
		result.way              = any_hit ? WAY_IDX_W'(hit_way) : WAY_IDX_W'(victim);
		result.victim_was_valid = !any_hit && old_valid[victim];
	end

endmodule

// ===== hw/rtl/set_assoc_cache_tag_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit
// Tag store of a set-associative cache with age-counter LRU or LFSR-based
// random replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, address): one transaction per access.
//   The set row is read from the tag memory at the accept edge; once the
//   output register is free, the update step compares tags, updates ages,
//   fills the victim on a miss, writes the row back and loads the output register.
//   Output channel (out_valid/out_stall): hit, way_used, set_used and
//   victim_was_valid, one transaction per access, in order.
//   A new access is not taken before the last one has finished the
//   read-modify-write of the row memory; in_stall stays high while an access is open.
//   A stalled result holds the update step, which waits for the output
//   register to free up; the read row is held in the memory output register.
//   Configuration (cfg_wr_en/cfg_addr/cfg_wdata): user writes it only while idle; block does not enforce.
//   Reset: all rows read as invalid with age zero, the LFSR returns to one,
//   sets_log2=3, ways_log2=0, policy LRU. No clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_unit
	import satl_pkg::*;
#(
	parameter int MAX_SETS    = 64,
	parameter int MAX_WAYS    = 8,
	parameter int OFFSET_BITS = 2,
	parameter int AGE_WIDTH   = 8,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ADDR_WIDTH-1:0] address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [WAY_OUT_W-1:0]  way_used,
	output logic [SET_OUT_W-1:0]  set_used,
	output logic                  victim_was_valid
);

	localparam int SLOG_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int WLOG_MAX = $clog2(MAX_WAYS + 1) - 1;
	localparam int NROWS    = 1 << SLOG_MAX;
	localparam int NWAYS    = 1 << WLOG_MAX;
	localparam int SET_W    = (SLOG_MAX > 0) ? SLOG_MAX : 1;
	localparam int WAY_W    = (WLOG_MAX > 0) ? WLOG_MAX : 1;
	localparam int TAG_W    = (ADDR_WIDTH > OFFSET_BITS) ? (ADDR_WIDTH - OFFSET_BITS) : 1;
	localparam int EXT_W    = ADDR_WIDTH + SET_W;

	logic [SETS_LOG2_W-1:0] sets_log2_q;
	logic [WAYS_LOG2_W-1:0] ways_log2_q;
	logic                   policy_q;
	logic [LFSR_W-1:0]      lfsr_q;
	logic                   busy_q;
	logic                   out_valid_q;

	logic [TAG_W-1:0]       tag_s1;
	logic [SET_W-1:0]       set_s1;

	logic                   hit_q;
	logic [WAY_OUT_W-1:0]   way_q;
	logic [SET_OUT_W-1:0]   set_q;
	logic                   was_valid_q;

	logic                   in_acc;
	logic                   finish;
	logic [SETS_LOG2_W-1:0] slog_eff;
	logic [WAYS_LOG2_W-1:0] wlog_eff;
	logic [SET_W-1:0]       set_mask;
	logic [EXT_W-1:0]       addr_ext;
	logic [SET_W-1:0]       set_in;
	logic [TAG_W-1:0]       tag_in;

	logic [NWAYS-1:0]                old_valid;
	logic [NWAYS-1:0][TAG_W-1:0]     old_tag;
	logic [NWAYS-1:0][AGE_WIDTH-1:0] old_age;
	logic [NWAYS-1:0]                new_valid;
	logic [NWAYS-1:0][TAG_W-1:0]     new_tag;
	logic [NWAYS-1:0][AGE_WIDTH-1:0] new_age;
	satl_result_t                    result;

	assign slog_eff = (int'(sets_log2_q) > SLOG_MAX) ? SETS_LOG2_W'(SLOG_MAX) : sets_log2_q;
	assign wlog_eff = (int'(ways_log2_q) > WLOG_MAX) ? WAYS_LOG2_W'(WLOG_MAX) : ways_log2_q;
	assign set_mask = SET_W'((1 << slog_eff) - 1);
	assign addr_ext = EXT_W'(address) >> OFFSET_BITS;
	assign set_in   = addr_ext[SET_W-1:0] & set_mask;
	assign tag_in   = TAG_W'(addr_ext >> slog_eff);

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign finish   = busy_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sets_log2_q <= SETS_LOG2_RST;
			ways_log2_q <= WAYS_LOG2_RST;
			policy_q    <= POLICY_LRU;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_SETS_LOG2: begin
					sets_log2_q <= cfg_wdata[SETS_LOG2_W-1:0];
				end
				REG_WAYS_LOG2: begin
					ways_log2_q <= cfg_wdata[WAYS_LOG2_W-1:0];
				end
				REG_POLICY: begin
					policy_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q      <= LFSR_SEED;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				lfsr_q <= lfsr_next(lfsr_q);
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_s1 <= tag_in;
			set_s1 <= set_in;
		end
		if (finish) begin
			hit_q       <= result.hit;
			way_q       <= WAY_OUT_W'(result.way);
			set_q       <= SET_OUT_W'(set_s1);
			was_valid_q <= result.victim_was_valid;
		end
	end

	satl_tag_store #(
		.NROWS     (NROWS),
		.SET_W     (SET_W),
		.NWAYS     (NWAYS),
		.TAG_W     (TAG_W),
		.AGE_WIDTH (AGE_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_addr  (set_in),
		.rd_valid (old_valid),
		.rd_tag   (old_tag),
		.rd_age   (old_age),
		.wr_en    (finish),
		.wr_addr  (set_s1),
		.wr_valid (new_valid),
		.wr_tag   (new_tag),
		.wr_age   (new_age)
	);

	satl_update #(
		.NWAYS     (NWAYS),
		.WAY_W     (WAY_W),
		.TAG_W     (TAG_W),
		.AGE_WIDTH (AGE_WIDTH)
	) u_update (
		.old_valid (old_valid),
		.old_tag   (old_tag),
		.old_age   (old_age),
		.tag       (tag_s1),
		.ways_log2 (wlog_eff),
		.policy    (policy_q),
		.lfsr      (lfsr_q),
		.new_valid (new_valid),
		.new_tag   (new_tag),
		.new_age   (new_age),
		.result    (result)
	);

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign way_used         = way_q;
	assign set_used         = set_q;
	assign victim_was_valid = was_valid_q;

endmodule

// ===== hw/rtl/satl_checker.sv =====
// ----------------------------------------------------------------------------
// satl_checker
// Port-level checks on the tag lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module satl_checker
	import satl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  hit,
	input logic [WAY_OUT_W-1:0]  way_used,
	input logic [SET_OUT_W-1:0]  set_used,
	input logic                  victim_was_valid
);

	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an access is open");

	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> !victim_was_valid)
		else $error("victim flag set on a hit");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without an access two edges back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(way_used)
			&& $stable(set_used) && $stable(victim_was_valid)))
		else $error("stalled result changed");

endmodule

bind set_assoc_cache_tag_lookup_unit satl_checker u_satl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.hit              (hit),
	.way_used         (way_used),
	.set_used         (set_used),
	.victim_was_valid (victim_was_valid)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for set_assoc_cache_tag_lookup_unit. A queue of
// accesses, register writes and drain points drives the input side. Each
// accepted access is run through a behavioral copy of the tag store: valid
// bits, tags, age counters and the replacement LFSR. The copy gives the
// expected hit, way, set and victim state. A clocked monitor checks every
// result transaction against the oldest expected lookup. Stimulus starts
// with directed corner cases: address extremes, LRU eviction, duplicate tags
// after a geometry change, random replacement, out-of-range geometry and age
// saturation. Random phases follow under varied geometry and policy, with
// random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_top
	import satl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_SETS  = 64;
	localparam int ROW_WAYS  = 8;
	localparam int OFFSET_W  = 2;
	localparam int SET_LOG2_TOP = 6;
	localparam int TAG_W     = 30;
	localparam logic [7:0] AGE_TOP = 8'hFF;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [1:0] {STEP_ACCESS, STEP_WRITE, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		logic [31:0]           addr;
		logic [CFG_ADDR_W-1:0] reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		bit                    quiet;
	} step_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic [SET_OUT_W-1:0] set;
		logic                 victim_valid;
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           address = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  hit;
	logic [WAY_OUT_W-1:0]  way_used;
	logic [SET_OUT_W-1:0]  set_used;
	logic                  victim_was_valid;

	step_t   pending_steps [$];
	lookup_t expected_lookups [$];

	bit                    line_present [ROW_SETS*ROW_WAYS];
	logic [TAG_W-1:0]      line_tag_q [ROW_SETS*ROW_WAYS];
	logic [7:0]            line_age_q [ROW_SETS*ROW_WAYS];
	logic [LFSR_W-1:0]     repl_lfsr = LFSR_SEED;
	logic [SETS_LOG2_W-1:0] model_sets_log2 = SETS_LOG2_RST;
	logic [WAYS_LOG2_W-1:0] model_ways_log2 = WAYS_LOG2_RST;
	logic                  model_policy = POLICY_LRU;

	bit access_taken = 1'b0;
	bit fill_quiet = 1'b0;
	bit calm = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int errors = 0;
	int hit_count = 0;
	int miss_count = 0;
	int refill_count = 0;
	int settings_used = 0;

	set_assoc_cache_tag_lookup_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.address          (address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.way_used         (way_used),
		.set_used         (set_used),
		.victim_was_valid (victim_was_valid)
	);

	always #5 clk = ~clk;

	function automatic lookup_t predict_lookup(input logic [31:0] addr);
		int slog;
		int nways;
		int set_idx;
		int row;
		int victim;
		logic [TAG_W-1:0] tag;
		logic [7:0] best;
		lookup_t res;
		slog = (model_sets_log2 > SET_LOG2_TOP) ? SET_LOG2_TOP : model_sets_log2;
		nways = 1 << model_ways_log2;
		set_idx = (addr >> OFFSET_W) & ((1 << slog) - 1);
		tag = TAG_W'(addr >> (OFFSET_W + slog));
		row = set_idx * ROW_WAYS;
		res = '0;
		res.set = SET_OUT_W'(set_idx);
		repl_lfsr = (repl_lfsr >> 1) ^ (repl_lfsr[0] ? LFSR_TAPS : '0);
		for (int w = 0; w < nways; w++) begin
			if (line_present[row+w] && line_tag_q[row+w] == tag) begin
				if (!res.hit) begin
					res.way = WAY_OUT_W'(w);
				end
				res.hit = 1'b1;
				line_age_q[row+w] = '0;
			end else if (line_age_q[row+w] != AGE_TOP) begin
				line_age_q[row+w] = line_age_q[row+w] + 8'd1;
			end
		end
		if (!res.hit) begin
			victim = 0;
			best = line_age_q[row];
			if (model_policy == POLICY_LRU) begin
				for (int w = 1; w < nways; w++) begin
					if (line_age_q[row+w] > best) begin
						best = line_age_q[row+w];
						victim = w;
					end
				end
			end else begin
				victim = repl_lfsr & (nways - 1);
			end
			res.victim_valid = line_present[row+victim];
			res.way = WAY_OUT_W'(victim);
			line_present[row+victim] = 1'b1;
			line_tag_q[row+victim] = tag;
			line_age_q[row+victim] = '0;
		end
		return res;
	endfunction

	task automatic queue_access(input logic [31:0] addr);
		step_t s;
		s.kind = STEP_ACCESS;
		s.addr = addr;
		s.reg_idx = '0;
		s.reg_data = '0;
		s.quiet = fill_quiet;
		pending_steps.push_back(s);
	endtask

	task automatic queue_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		step_t s;
		s.kind = STEP_WRITE;
		s.addr = '0;
		s.reg_idx = idx;
		s.reg_data = data;
		s.quiet = fill_quiet;
		pending_steps.push_back(s);
	endtask

	task automatic queue_random_phase(input logic [SETS_LOG2_W-1:0] sl,
			input logic [WAYS_LOG2_W-1:0] wl, input logic pol, input int count);
		logic [31:0] pool [$];
		logic [31:0] shared_low;
		logic [31:0] a;
		step_t s;
		int pool_n;
		queue_write(REG_SETS_LOG2, sl);
		queue_write(REG_WAYS_LOG2, CFG_DATA_W'(wl));
		queue_write(REG_POLICY, CFG_DATA_W'(pol));
		settings_used++;
		pool_n = $urandom_range(1, 24);
		shared_low = $urandom() & 32'h0000_00FC;
		for (int i = 0; i < pool_n; i++) begin
			a = $urandom();
			if ($urandom_range(0, 1) == 1) begin
				a = (a & ~32'h0000_00FC) | shared_low;
			end
			pool.push_back(a);
		end
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				s.kind = STEP_DRAIN;
				s.addr = '0;
				s.reg_idx = '0;
				s.reg_data = '0;
				s.quiet = fill_quiet;
				pending_steps.push_back(s);
			end
			if ($urandom_range(0, 3) == 0) begin
				queue_access($urandom());
			end else begin
				queue_access(pool[$urandom_range(0, pool_n - 1)] ^ $urandom_range(0, 3));
			end
		end
	endtask

	// input side: hold until accepted, then advance to the next step
	always @(negedge clk) begin
		step_t head;
		logic valid_nx;
		logic wr_nx;
		logic [31:0] addr_nx;
		logic [CFG_ADDR_W-1:0] idx_nx;
		logic [CFG_DATA_W-1:0] data_nx;
		bit calm_nx;
		if (arst_n) begin
			valid_nx = 1'b0;
			wr_nx = 1'b0;
			addr_nx = address;
			idx_nx = cfg_addr;
			data_nx = cfg_wdata;
			calm_nx = calm;
			if (in_valid && !access_taken) begin
				valid_nx = 1'b1;
			end else begin
				access_taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_steps.size() != 0) begin
					head = pending_steps[0];
					case (head.kind)
						STEP_ACCESS: begin
							if (!head.quiet && $urandom_range(0, 4) == 0) begin
								gap_left = $urandom_range(0, 2);
							end else begin
								valid_nx = 1'b1;
								addr_nx = head.addr;
								calm_nx = head.quiet;
								void'(pending_steps.pop_front());
							end
						end
						STEP_WRITE: begin
							if (expected_lookups.size() == 0) begin
								wr_nx = 1'b1;
								idx_nx = head.reg_idx;
								data_nx = head.reg_data;
								void'(pending_steps.pop_front());
							end
						end
						default: begin
							if (expected_lookups.size() == 0) begin
								void'(pending_steps.pop_front());
							end
						end
					endcase
				end
			end
			in_valid <= valid_nx;
			address <= addr_nx;
			cfg_wr_en <= wr_nx;
			cfg_addr <= idx_nx;
			cfg_wdata <= data_nx;
			calm <= calm_nx;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (calm) begin
				stall_left = 0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_SETS_LOG2: model_sets_log2 = cfg_wdata[SETS_LOG2_W-1:0];
					REG_WAYS_LOG2: model_ways_log2 = cfg_wdata[WAYS_LOG2_W-1:0];
					REG_POLICY:    model_policy = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				access_taken = 1'b1;
				expected_lookups.push_back(predict_lookup(address));
			end
		end
	end

	always @(posedge clk) begin
		lookup_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lookups.size() == 0) begin
				$error("result transaction with no lookup pending: hit=%0d way=%0d set=%0d",
					hit, way_used, set_used);
				errors++;
			end else begin
				exp_r = expected_lookups.pop_front();
				if (hit !== exp_r.hit) begin
					$error("hit mismatch: expected %0d, actual %0d", exp_r.hit, hit);
					errors++;
				end
				if (way_used !== exp_r.way) begin
					$error("way_used mismatch: expected %0d, actual %0d", exp_r.way, way_used);
					errors++;
				end
				if (set_used !== exp_r.set) begin
					$error("set_used mismatch: expected %0d, actual %0d", exp_r.set, set_used);
					errors++;
				end
				if (victim_was_valid !== exp_r.victim_valid) begin
					$error("victim_was_valid mismatch: expected %0d, actual %0d",
						exp_r.victim_valid, victim_was_valid);
					errors++;
				end
				if (exp_r.hit) begin
					hit_count++;
				end else begin
					miss_count++;
				end
				if (exp_r.victim_valid) begin
					refill_count++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < ROW_SETS * ROW_WAYS; i++) begin
			line_present[i] = 1'b0;
			line_tag_q[i] = '0;
			line_age_q[i] = '0;
		end

		// reset geometry: 8 sets, 1 way, LRU
		settings_used = 1;
		queue_access(32'h0000_0000);
		queue_access(32'h0000_0000);
		queue_access(32'hFFFF_FFFF);
		queue_access(32'hFFFF_FFFC);
		queue_access(32'h0000_0020);

		// out-of-range set count saturates to 64; fill one set then evict LRU
		queue_write(REG_SETS_LOG2, 3'd7);
		queue_write(REG_WAYS_LOG2, 3'd3);
		queue_write(REG_POLICY, CFG_DATA_W'(POLICY_LRU));
		settings_used++;
		for (int k = 0; k < 9; k++) begin
			queue_access(32'h0000_0014 + k * 256);
		end
		queue_access(32'h0000_0114);

		// duplicate tag in one set after shrinking and regrowing the way count
		queue_access(32'h0000_0024);
		queue_access(32'h0000_0124);
		queue_write(REG_WAYS_LOG2, 3'd0);
		queue_access(32'h0000_0124);
		queue_write(REG_WAYS_LOG2, 3'd3);
		queue_access(32'h0000_0124);

		// random replacement, upper data bit ignored, spare index ignored
		queue_write(REG_POLICY, CFG_DATA_W'(POLICY_RANDOM));
		queue_write(REG_WAYS_LOG2, 3'b110);
		queue_write(REG_SPARE, 3'b111);
		settings_used++;
		for (int k = 0; k < 4; k++) begin
			queue_access(k * 256);
		end

		// age saturation: one set, eight ways, one hot line
		queue_write(REG_SETS_LOG2, 3'd0);
		queue_write(REG_WAYS_LOG2, 3'd3);
		queue_write(REG_POLICY, CFG_DATA_W'(POLICY_LRU));
		settings_used++;
		for (int k = 0; k < 8; k++) begin
			queue_access(k * 4);
		end
		for (int k = 0; k < 300; k++) begin
			queue_access(32'h0000_0000);
		end
		for (int k = 0; k < 8; k++) begin
			queue_access((100 + k) * 4);
		end

		queue_random_phase(3'd0, 2'd0, POLICY_LRU, 110);
		queue_random_phase(3'd7, 2'd3, POLICY_LRU, 110);
		queue_random_phase(3'd7, 2'd3, POLICY_RANDOM, 110);
		queue_random_phase(3'd0, 2'd3, POLICY_RANDOM, 110);
		queue_random_phase(3'd6, 2'd0, POLICY_RANDOM, 110);
		for (int p = 0; p < 3; p++) begin
			queue_random_phase(SETS_LOG2_W'($urandom_range(0, 7)),
				WAYS_LOG2_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 100);
		end
		fill_quiet = 1'b1;
		queue_random_phase(SETS_LOG2_W'($urandom_range(0, 7)),
			WAYS_LOG2_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 110);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_steps.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		while (expected_lookups.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);

		$display("Checked %0d lookups: %0d hits, %0d misses, %0d refills of valid lines.",
			hit_count + miss_count, hit_count, miss_count, refill_count);
		$display("Covered %0d geometry and replacement settings, including age saturation.",
			settings_used);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
